>>> hdl/tess_pkg.sv
// Shared types, widths and codes for the two-ended shared stack.
`timescale 1ns / 1ps
`default_nettype none
package tess_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

>>> hdl/tess_store.sv
// Shared stack store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tess_store (
    input  wire logic                     i_clk,
    input  wire tess_pkg::t_mem_req       i_req,
    output logic [tess_pkg::DATA_W-1:0]   o_rdata
);
    import tess_pkg::*;

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/tess_ctrl.sv
// Command sequencer: stack counts, store access, search walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module tess_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tess_pkg::CMD_W-1:0]     i_command,
    input  wire logic                           i_side,
    input  wire logic [tess_pkg::DATA_W-1:0]    i_operand_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [tess_pkg::STAT_W-1:0]         o_status,
    output logic [tess_pkg::DATA_W-1:0]         o_read_value,
    output logic [tess_pkg::CNT_W-1:0]          o_match_depth,
    output logic [tess_pkg::CNT_W-1:0]          o_left_size,
    output logic [tess_pkg::CNT_W-1:0]          o_right_size,
    input  wire logic [tess_pkg::CNT_W-1:0]     i_cap,
    input  wire logic                           i_clear_all,
    output tess_pkg::t_mem_req                  o_mem_req,
    input  wire logic [tess_pkg::DATA_W-1:0]    i_mem_rdata
);
    import tess_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_right, n_right;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic              r_side, n_side;
    logic [DATA_W-1:0] r_val, n_val;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_rd;
    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_lsize;
    logic [CNT_W-1:0]  r_rsize;

    logic              out_free;
    logic              accept;
    logic [CNT_W:0]    sum;
    logic              bad;
    logic [CNT_W-1:0]  left_e;
    logic [CNT_W-1:0]  right_e;
    logic [CNT_W:0]    sum_e;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  cap_m_cnt;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  rpush;
    logic [ADDR_W-1:0] top_addr;
    logic [CNT_W-1:0]  idx_p1;
    logic [ADDR_W-1:0] next_addr;
    logic              load;
    logic [STAT_W-1:0] res_status;
    logic [DATA_W-1:0] res_rd;
    logic [CNT_W-1:0]  res_depth;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && (r_state == S_IDLE) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);

    assign sum       = {1'b0, r_left} + {1'b0, r_right};
    assign bad       = sum > {1'b0, i_cap};
    assign left_e    = bad ? '0 : r_left;
    assign right_e   = bad ? '0 : r_right;
    assign sum_e     = bad ? '0 : sum;
    assign cnt       = i_side ? right_e : left_e;
    assign cap_m_cnt = i_cap - cnt;
    assign cnt_m1    = cnt - CNT_W'(1);
    assign rpush     = i_cap - right_e - CNT_W'(1);
    assign top_addr  = i_side ? cap_m_cnt[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    assign idx_p1    = r_idx + CNT_W'(1);
    assign next_addr = r_side ? (r_addr + ADDR_W'(1)) : (r_addr - ADDR_W'(1));

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_right    = r_right;
        n_cmd      = r_cmd;
        n_side     = r_side;
        n_val      = r_val;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        o_mem_req  = '0;
        load       = 1'b0;
        res_status = ST_OK;
        res_rd     = '0;
        res_depth  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_left  = left_e;
                    n_right = right_e;
                    n_cmd   = i_command;
                    n_side  = i_side;
                    n_val   = i_operand_value;
                    n_cnt   = cnt;
                    case (i_command)
                        CMD_PUSH: begin
                            load = 1'b1;
                            if (sum_e >= {1'b0, i_cap}) begin
                                res_status = ST_FULL;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.wdata = i_operand_value;
                                if (i_side) begin
                                    o_mem_req.waddr = rpush[ADDR_W-1:0];
                                    n_right         = right_e + CNT_W'(1);
                                end else begin
                                    o_mem_req.waddr = left_e[ADDR_W-1:0];
                                    n_left          = left_e + CNT_W'(1);
                                end
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (cnt == '0) begin
                                load       = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = top_addr;
                                n_state         = S_READ;
                            end
                        end
                        CMD_CLEAR: begin
                            load = 1'b1;
                            if (i_side) begin
                                n_right = '0;
                            end else begin
                                n_left = '0;
                            end
                        end
                        CMD_SEARCH: begin
                            if (cnt == '0) begin
                                load       = 1'b1;
                                res_status = ST_NOTFOUND;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = top_addr;
                                n_addr          = top_addr;
                                n_idx           = '0;
                                n_state         = S_SRCH;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                load    = 1'b1;
                res_rd  = i_mem_rdata;
                n_state = S_IDLE;
                if (r_cmd == CMD_POP) begin
                    if (r_side) begin
                        n_right = r_right - CNT_W'(1);
                    end else begin
                        n_left = r_left - CNT_W'(1);
                    end
                end
            end
            S_SRCH: begin
                if (i_mem_rdata == r_val) begin
                    load      = 1'b1;
                    res_depth = idx_p1;
                    n_state   = S_IDLE;
                end else if (idx_p1 == r_cnt) begin
                    load       = 1'b1;
                    res_status = ST_NOTFOUND;
                    n_state    = S_IDLE;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = next_addr;
                    n_addr          = next_addr;
                    n_idx           = idx_p1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_clear_all) begin
            n_left  = '0;
            n_right = '0;
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_right     <= n_right;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_side <= n_side;
        r_val  <= n_val;
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        if (load) begin
            r_status <= res_status;
            r_rd     <= res_rd;
            r_depth  <= res_depth;
            r_lsize  <= n_left;
            r_rsize  <= n_right;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_match_depth = r_depth;
    assign o_left_size   = r_lsize;
    assign o_right_size  = r_rsize;

endmodule
`default_nettype wire

>>> hdl/two_ended_shared_stack_unit.sv
// Two-ended shared stack: top level with capacity register and store.
//
//  channel | valid       | flow control  | payload
//  --------+-------------+---------------+-----------------------------------------
//  in      | i_in_valid  | o_in_stall    | i_command, i_side, i_operand_value
//  out     | o_out_valid | i_out_stall   | o_status, o_read_value, o_match_depth,
//          |             |               | o_left_size, o_right_size
//  cfg     | i_cfg_valid | o_cfg_ready   | i_cfg_capacity_in_use
//
// Push, clear and unknown commands need no store read; pop and peek wait for the registered
// store read, or need none when the side is empty.
// Search walks at most the side's size entries from the top, stopping at the first match,
// one store read per cycle on the single read port.
// Reset zeroes both sizes and sets capacity to 1024; store contents are not cleared.
// Input stalls while an item is in progress or a finished result is held by i_out_stall.
`timescale 1ns / 1ps
`default_nettype none
module two_ended_shared_stack_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tess_pkg::CMD_W-1:0]     i_command,
    input  wire logic                           i_side,
    input  wire logic signed [31:0]             i_operand_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [tess_pkg::STAT_W-1:0]         o_status,
    output logic signed [31:0]                  o_read_value,
    output logic [tess_pkg::CNT_W-1:0]          o_match_depth,
    output logic [tess_pkg::CNT_W-1:0]          o_left_size,
    output logic [tess_pkg::CNT_W-1:0]          o_right_size,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tess_pkg::CNT_W-1:0]     i_cfg_capacity_in_use
);
    import tess_pkg::*;

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  cap_eff;
    logic              cfg_wr;
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] rd_value;
    logic [CNT_W:0]    out_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(STORE_DEPTH);
        end else if (cfg_wr) begin
            r_cap <= i_cfg_capacity_in_use;
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > CNT_W'(STORE_DEPTH)) begin
            cap_eff = CNT_W'(STORE_DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    tess_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    tess_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_side          (i_side),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_read_value    (rd_value),
        .o_match_depth   (o_match_depth),
        .o_left_size     (o_left_size),
        .o_right_size    (o_right_size),
        .i_cap           (cap_eff),
        .i_clear_all     (cfg_wr),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata)
    );

    assign o_read_value = rd_value;
    assign out_sum      = {1'b0, o_left_size} + {1'b0, o_right_size};

    a_sizes_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> out_sum <= {1'b0, cap_eff})
        else $error("stack sizes exceed capacity");

    a_full_means_met: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> out_sum == {1'b0, cap_eff})
        else $error("full status while stacks have room");

    a_empty_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_read_value == '0 && o_match_depth == '0))
        else $error("empty status carries data");

    a_depth_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_depth != '0) |-> o_status == ST_OK)
        else $error("match depth without ok status");

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench for the two-ended shared stack: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module tb;
    import tess_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;
    localparam int IDLE_PCT      = 16;
    localparam int QUIET_FROM    = 900;
    localparam int QUIET_TO      = 1200;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 152;
    localparam int TAIL_CYCLES   = 64;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              side;
        logic [DATA_W-1:0] operand;
    } stack_op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  match_depth;
        logic [CNT_W-1:0]  left_size;
        logic [CNT_W-1:0]  right_size;
    } stack_reply_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = '0;
    logic                     i_side = 1'b0;
    logic signed [31:0]       i_operand_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [STAT_W-1:0]        o_status;
    logic signed [31:0]       o_read_value;
    logic [CNT_W-1:0]         o_match_depth;
    logic [CNT_W-1:0]         o_left_size;
    logic [CNT_W-1:0]         o_right_size;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CNT_W-1:0]         i_cfg_capacity_in_use = '0;

    two_ended_shared_stack_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_command             (i_command),
        .i_side                (i_side),
        .i_operand_value       (i_operand_value),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_read_value          (o_read_value),
        .o_match_depth         (o_match_depth),
        .o_left_size           (o_left_size),
        .o_right_size          (o_right_size),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_capacity_in_use (i_cfg_capacity_in_use)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    stack_op_t    pending_ops[$];
    stack_reply_t predicted_replies[$];

    logic [DATA_W-1:0] stack_mirror [STORE_DEPTH];
    logic [CNT_W-1:0]  capacity_reg = CNT_W'(STORE_DEPTH);
    int                left_depth = 0;
    int                right_depth = 0;

    int in_offered = 0;
    int in_taken = 0;
    int out_taken = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    logic [DATA_W-1:0] value_pool [8];

    function automatic stack_reply_t predict_stack_reply(input stack_op_t op);
        stack_reply_t r;
        int cap;
        int cnt;
        int top;
        int addr;
        bit found;
        cap = (capacity_reg < 1) ? 1 : int'(capacity_reg);
        if (cap > STORE_DEPTH) cap = STORE_DEPTH;
        r = '0;
        r.status = ST_OK;
        if (left_depth + right_depth > cap) begin
            left_depth = 0;
            right_depth = 0;
        end
        cnt = op.side ? right_depth : left_depth;
        top = op.side ? cap - cnt : cnt - 1;
        case (op.command)
            CMD_PUSH: begin
                if (left_depth + right_depth >= cap) begin
                    r.status = ST_FULL;
                end else if (op.side) begin
                    right_depth++;
                    stack_mirror[(cap - right_depth) % STORE_DEPTH] = op.operand;
                end else begin
                    stack_mirror[left_depth % STORE_DEPTH] = op.operand;
                    left_depth++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = stack_mirror[top % STORE_DEPTH];
                    if (op.command == CMD_POP) begin
                        if (op.side) right_depth--;
                        else left_depth--;
                    end
                end
            end
            CMD_CLEAR: begin
                if (op.side) right_depth = 0;
                else left_depth = 0;
            end
            CMD_SEARCH: begin
                r.status = ST_NOTFOUND;
                found = 1'b0;
                for (int i = 0; i < cnt; i++) begin
                    addr = op.side ? top + i : top - i;
                    if (!found && stack_mirror[addr % STORE_DEPTH] == op.operand) begin
                        found = 1'b1;
                        r.status = ST_OK;
                        r.match_depth = CNT_W'(i + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        r.left_size = CNT_W'(left_depth);
        r.right_size = CNT_W'(right_depth);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        stack_reply_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                capacity_reg = i_cfg_capacity_in_use;
                left_depth = 0;
                right_depth = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                predicted_replies.push_back(predict_stack_reply(
                    '{command: i_command, side: i_side, operand: i_operand_value}));
                in_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                out_taken++;
                if (predicted_replies.size() == 0) begin
                    $error("result item with no prediction pending");
                    mismatches++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("read_value", want.read_value, o_read_value);
                    check_field("match_depth", 32'(want.match_depth), 32'(o_match_depth));
                    check_field("left_size", 32'(want.left_size), 32'(o_left_size));
                    check_field("right_size", 32'(want.right_size), 32'(o_right_size));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        stack_op_t op;
        bit quiet;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (in_offered == in_taken) begin
            quiet = (in_taken >= QUIET_FROM) && (in_taken < QUIET_TO);
            if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                op = pending_ops.pop_front();
                i_command <= op.command;
                i_side <= op.side;
                i_operand_value <= op.operand;
                i_in_valid <= 1'b1;
                in_offered++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && out_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (out_taken >= QUIET_FROM && out_taken < QUIET_TO) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic add_op(input logic [CMD_W-1:0] cmd, input logic sd,
                          input logic [DATA_W-1:0] val);
        pending_ops.push_back('{command: cmd, side: sd, operand: val});
    endtask

    function automatic logic [CMD_W-1:0] CMD_CommandRsvd();
        return CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    endfunction

    task automatic add_random_op();
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) cmd = CMD_PUSH;
        else if (roll < 55) cmd = CMD_POP;
        else if (roll < 65) cmd = CMD_PEEK;
        else if (roll < 85) cmd = CMD_SEARCH;
        else if (roll < 91) cmd = CMD_CLEAR;
        else if (roll < 96) cmd = CMD_CommandRsvd();
        else cmd = CMD_PUSH;
        roll = $urandom_range(0, 99);
        if (roll < 55) val = value_pool[$urandom_range(0, 7)];
        else val = $urandom;
        add_op(cmd, 1'($urandom_range(0, 1)), val);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_offered != in_taken ||
               predicted_replies.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_drained();
        @(negedge i_clk);
        i_cfg_capacity_in_use <= cap;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CNT_W-1:0] caps [12];
        caps = '{11'd0, 11'd2047, 11'd2, 11'd1024, 11'd3, 11'd0, 11'd7, 11'd1,
                 11'd16, 11'd0, 11'd64, 11'd5};
        caps[5] = CNT_W'($urandom_range(1, 2047));
        caps[9] = CNT_W'($urandom_range(1, 2047));
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_op(CMD_POP, SIDE_LEFT, 32'h0);
        add_op(CMD_PEEK, SIDE_RIGHT, 32'h0);
        add_op(CMD_SEARCH, SIDE_LEFT, 32'h0);
        add_op(CMD_PUSH, SIDE_LEFT, 32'h7FFF_FFFF);
        add_op(CMD_PUSH, SIDE_LEFT, 32'h8000_0000);
        add_op(CMD_PUSH, SIDE_RIGHT, 32'h0000_0000);
        add_op(CMD_PUSH, SIDE_RIGHT, 32'hFFFF_FFFF);
        add_op(CMD_PEEK, SIDE_LEFT, 32'h0);
        add_op(CMD_PEEK, SIDE_RIGHT, 32'h0);
        add_op(CMD_SEARCH, SIDE_LEFT, 32'h7FFF_FFFF);
        add_op(CMD_SEARCH, SIDE_RIGHT, 32'h0000_0000);
        add_op(CMD_SEARCH, SIDE_RIGHT, 32'h1234_5678);
        add_op(CMD_POP, SIDE_RIGHT, 32'h0);
        add_op(CMD_RSVD_LO, SIDE_LEFT, 32'hFFFF_FFFF);
        add_op(CMD_RSVD_LO + 3'd1, SIDE_RIGHT, 32'h0);
        add_op(CMD_RSVD_HI, SIDE_RIGHT, 32'h5A5A_A5A5);
        add_op(CMD_CLEAR, SIDE_LEFT, 32'h0);
        add_op(CMD_POP, SIDE_LEFT, 32'h0);
        add_op(CMD_CLEAR, SIDE_RIGHT, 32'h0);

        write_capacity(11'd1);
        add_op(CMD_PUSH, SIDE_RIGHT, 32'hAAAA_5555);
        add_op(CMD_PUSH, SIDE_LEFT, 32'h1);
        add_op(CMD_PEEK, SIDE_RIGHT, 32'h0);
        add_op(CMD_POP, SIDE_RIGHT, 32'h0);
        add_op(CMD_PUSH, SIDE_LEFT, 32'h5555_AAAA);
        add_op(CMD_SEARCH, SIDE_LEFT, 32'h5555_AAAA);

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            value_pool[0] = 32'h0;
            value_pool[1] = 32'hFFFF_FFFF;
            value_pool[2] = 32'h8000_0000;
            value_pool[3] = 32'h7FFF_FFFF;
            for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
            repeat (PHASE_ITEMS) add_random_op();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hdl/tess_pkg.sv
hdl/tess_store.sv
hdl/tess_ctrl.sv
hdl/two_ended_shared_stack_unit.sv
test/tb.sv
